// ===== design/qws_pkg.sv =====
// Shared types and constants for the quoted word splitter.
package qws_pkg;

    localparam int MAX_WORDS = 255;
    localparam int WORDS_W   = $clog2(MAX_WORDS + 1);
    localparam int CHAR_W    = 8;
    localparam int COUNT_W   = 8;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'd34;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'd35;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_UNMATCHED = 1'b1;

    typedef enum logic [3:0] {
        MODE_START   = 4'b0001,
        MODE_QUOTED  = 4'b0010,
        MODE_WORD    = 4'b0100,
        MODE_COMMENT = 4'b1000
    } qws_mode_t;

    typedef struct packed {
        qws_mode_t          mode;
        logic               at_line_start;
        logic [WORDS_W-1:0] words;
    } qws_state_t;

    typedef struct packed {
        logic               valid;
        logic [CHAR_W-1:0]  out_char;
        logic               char_valid;
        logic               word_end;
        logic               line_done;
        logic [COUNT_W-1:0] word_count;
        logic               status;
    } qws_result_t;

endpackage

// ===== design/qws_step.sv =====
// Per-byte tokenizer step: next state and the result for one request.
module qws_step (
    input  qws_pkg::qws_state_t           cur,
    input  logic [qws_pkg::CHAR_W-1:0]    char_code,
    input  logic                          line_end,
    output qws_pkg::qws_state_t           nxt,
    output qws_pkg::qws_result_t          res
);
    import qws_pkg::*;

    logic               blank;
    logic [WORDS_W-1:0] words_inc;

    assign blank = (char_code == CH_SPACE) ||
                   ((char_code >= CH_TAB) && (char_code <= CH_CR));

    // Saturating word count
    assign words_inc = (cur.words < WORDS_W'(MAX_WORDS)) ?
                       cur.words + WORDS_W'(1) : cur.words;

    always_comb
    begin
        nxt = cur;
        res = '0;
        if (line_end)
        begin
            res.valid     = 1'b1;
            res.line_done = 1'b1;
            res.word_count = COUNT_W'(cur.words);
            if (cur.mode == MODE_WORD)
            begin
                res.word_end   = 1'b1;
                res.word_count = COUNT_W'(words_inc);
            end
            res.status = (cur.mode == MODE_QUOTED) ? STATUS_UNMATCHED : STATUS_OK;
            nxt.mode          = MODE_START;
            nxt.at_line_start = 1'b1;
            nxt.words         = '0;
        end
        else if (cur.mode == MODE_COMMENT)
        begin
            // drop every byte of a comment line
        end
        else if (cur.at_line_start && !blank && (char_code == CH_HASH))
        begin
            nxt.at_line_start = 1'b0;
            nxt.mode          = MODE_COMMENT;
        end
        else
        begin
            if (!blank)
                nxt.at_line_start = 1'b0;
            case (cur.mode)
                MODE_START:
                begin
                    if (char_code == CH_QUOTE)
                        nxt.mode = MODE_QUOTED;
                    else if (!blank)
                    begin
                        nxt.mode       = MODE_WORD;
                        res.valid      = 1'b1;
                        res.char_valid = 1'b1;
                        res.out_char   = char_code;
                    end
                end
                MODE_QUOTED:
                begin
                    if (char_code == CH_QUOTE)
                        nxt.mode = MODE_WORD;
                    else
                    begin
                        res.valid      = 1'b1;
                        res.char_valid = 1'b1;
                        res.out_char   = char_code;
                    end
                end
                MODE_WORD:
                begin
                    if (blank)
                    begin
                        nxt.words    = words_inc;
                        nxt.mode     = MODE_START;
                        res.valid    = 1'b1;
                        res.word_end = 1'b1;
                    end
                    else if (char_code == CH_QUOTE)
                        nxt.mode = MODE_QUOTED;
                    else
                    begin
                        res.valid      = 1'b1;
                        res.char_valid = 1'b1;
                        res.out_char   = char_code;
                    end
                end
                default:
                begin
                    nxt.mode = MODE_START;
                end
            endcase
        end
    end

endmodule

// ===== design/quoted_word_splitter.sv =====
// Top level of the quoted word splitter: stream ports, state and result register.
// A request that yields a result shows it on the master side in the cycle after the request is taken.
// Throughput: one request per cycle; the combinational next-state logic in qws_step
// sets that figure. A new request enters in the cycle a waiting result is taken;
// while a result waits with m_axis_tready low, the input stalls.
// Reset (rst_n low, asynchronous): word-start mode, line start, zero words, no result pending.
// The output payload register is not reset; only its valid flag is.
module quoted_word_splitter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [qws_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [7:0] char_code
    input  logic                              s_axis_tlast,  // line_end
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] out_char, [8] char_valid, [9] word_end, [17:10] word_count,
    // [18] status, [23:19] zero
    output logic [qws_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic                              m_axis_tlast   // line_done
);
    import qws_pkg::*;

    qws_state_t  state_reg;
    qws_state_t  state_next;
    qws_result_t step_res;

    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               char_valid_reg;
    logic               word_end_reg;
    logic               line_done_reg;
    logic [COUNT_W-1:0] word_count_reg;
    logic               status_reg;

    logic s_accept;
    logic m_accept;

    // Accept a new request whenever the result register is empty or draining.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_accept      = m_axis_tvalid && m_axis_tready;

    qws_step u_step (
        .cur       (state_reg),
        .char_code (s_axis_tdata[CHAR_W-1:0]),
        .line_end  (s_axis_tlast),
        .nxt       (state_next),
        .res       (step_res)
    );

    // Advance the tokenizer state only on an accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode          <= MODE_START;
            state_reg.at_line_start <= 1'b1;
            state_reg.words         <= '0;
        end
        else if (s_accept)
        begin
            state_reg <= state_next;
        end
    end

    // Result valid: load on a request that yields a result, clear when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_accept)
            out_valid_reg <= step_res.valid;
        else if (m_accept)
            out_valid_reg <= 1'b0;
    end

    // Hold the payload until a new result replaces it.
    always_ff @(posedge clk)
    begin
        if (s_accept && step_res.valid)
        begin
            out_char_reg   <= step_res.out_char;
            char_valid_reg <= step_res.char_valid;
            word_end_reg   <= step_res.word_end;
            line_done_reg  <= step_res.line_done;
            word_count_reg <= step_res.word_count;
            status_reg     <= step_res.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = line_done_reg;
    assign m_axis_tdata  = {5'd0, status_reg, word_count_reg, word_end_reg,
                            char_valid_reg, out_char_reg};

    // A line end always returns the tokenizer to its line-start state.
    a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_axis_tlast |=>
            state_reg.mode == MODE_START && state_reg.at_line_start &&
            state_reg.words == '0)
        else $error("state not restored after line end");

    // Word count never passes its saturation limit.
    a_words_sat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.words <= WORDS_W'(MAX_WORDS))
        else $error("word count above limit");

    // In comment mode the line-start flag is always clear.
    a_comment_flag: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.mode == MODE_COMMENT |-> !state_reg.at_line_start)
        else $error("comment mode with line-start flag set");

    // A line-done result never carries a word byte.
    a_done_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[8])
        else $error("line done result carries a byte");

    // Bytes inside a comment line yield no result.
    a_comment_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && !s_axis_tlast && state_reg.mode == MODE_COMMENT |=> !m_axis_tvalid)
        else $error("comment byte produced a result");

endmodule
